// ===== rtl/keystroke_keyword_detector_core_assert.svh =====
// Assertion macros for the keyword detector core RTL.
`ifndef KEYSTROKE_KEYWORD_DETECTOR_CORE_ASSERT_SVH
`define KEYSTROKE_KEYWORD_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KKD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kkd_pkg.sv =====
// Types, constants and helpers for the keystroke keyword detector.
`default_nettype none

package kkd_pkg;

  localparam int unsigned NUM_KEYWORDS = 4;
  localparam int unsigned MAX_LEN      = 8;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned KW_W         = 64;
  localparam int unsigned LEN_W        = 4;
  localparam int unsigned PROG_W       = 3;
  localparam int unsigned CNT_W        = 3;
  localparam int unsigned LENS_W       = 16;
  localparam int unsigned CFG_IDX_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNT   = 3'd0,
    REG_CHARS_0 = 3'd1,
    REG_CHARS_1 = 3'd2,
    REG_CHARS_2 = 3'd3,
    REG_CHARS_3 = 3'd4,
    REG_LENGTHS = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [PROG_W-1:0] prog;
    logic              hit;
  } lane_res_t;

  // Length nibble to effective length: zero acts as one, clamp at MAX_LEN.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] nib);
    logic [LEN_W-1:0] len;
    len = nib;
    if (nib == '0) begin
      len = LEN_W'(1);
    end else if (nib > LEN_W'(MAX_LEN)) begin
      len = LEN_W'(MAX_LEN);
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kkd_lane.sv =====
// One keyword lane: compares a character and computes next progress and hit.
`default_nettype none

module kkd_lane (
  input  wire logic                     en_i,
  input  wire logic [kkd_pkg::KW_W-1:0]   chars_i,
  input  wire logic [kkd_pkg::LEN_W-1:0]  len_nib_i,
  input  wire logic [kkd_pkg::PROG_W-1:0] prog_i,
  input  wire logic [kkd_pkg::CHAR_W-1:0] key_char_i,
  output kkd_pkg::lane_res_t              res_o
);
  import kkd_pkg::*;

  logic [LEN_W-1:0]  len;
  logic [PROG_W-1:0] cur;
  logic [CHAR_W-1:0] expect_char;
  logic [LEN_W-1:0]  nxt;
  logic              done;

  always_comb begin
    len = eff_len(len_nib_i);
    // progress left over from a longer length restarts from zero
    cur = ({1'b0, prog_i} >= len) ? '0 : prog_i;
    expect_char = chars_i[{cur, 3'b000} +: CHAR_W];
    if (expect_char == key_char_i) begin
      nxt = {1'b0, cur} + LEN_W'(1);
    end else if (chars_i[CHAR_W-1:0] == key_char_i) begin
      nxt = LEN_W'(1);
    end else begin
      nxt = '0;
    end
    done = en_i && (nxt >= len);
    res_o.hit  = done;
    res_o.prog = (!en_i || done) ? '0 : nxt[PROG_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/keystroke_keyword_detector_core.sv =====
// Keystroke keyword detector: up to four keywords tracked per character.
// An accepted key_char beat is held in the input register; its match_mask goes to the result register.
// Throughput: one character per cycle while out_stall_i is low; the four lane comparators work in parallel.
// Reset: progress clears, keyword_count 0, keyword chars 0, lengths 0x1111.
// Any write to a defined register clears all match progress.
`default_nettype none

`include "keystroke_keyword_detector_core_assert.svh"

module keystroke_keyword_detector_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [kkd_pkg::CHAR_W-1:0]    key_char_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [kkd_pkg::NUM_KEYWORDS-1:0]   match_mask_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [kkd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [kkd_pkg::KW_W-1:0]      cfg_data_i
);
  import kkd_pkg::*;

  logic [CNT_W-1:0]                     count_q;
  logic [NUM_KEYWORDS-1:0][KW_W-1:0]    chars_q;
  logic [LENS_W-1:0]                    lengths_q;
  logic [NUM_KEYWORDS-1:0][PROG_W-1:0]  prog_q;
  logic [NUM_KEYWORDS-1:0][PROG_W-1:0]  prog_d;
  logic [NUM_KEYWORDS-1:0]              hit;
  lane_res_t                            lane_res [NUM_KEYWORDS];

  logic              in_valid_q;
  logic [CHAR_W-1:0] key_char_q;
  logic              out_valid_q;
  logic [NUM_KEYWORDS-1:0] mask_q;

  logic out_ready;
  logic advance;
  logic cfg_wr;
  logic cfg_clear;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_clear   = cfg_wr && (cfg_index_i <= CFG_IDX_W'(REG_LENGTHS));

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_ready;
  assign advance    = in_valid_q && out_ready;

  assign out_valid_o  = out_valid_q;
  assign match_mask_o = mask_q;

  for (genvar i = 0; i < NUM_KEYWORDS; i++) begin : g_lane
    kkd_lane u_lane (
      .en_i      (count_q > CNT_W'(i)),
      .chars_i   (chars_q[i]),
      .len_nib_i (lengths_q[LEN_W*i +: LEN_W]),
      .prog_i    (prog_q[i]),
      .key_char_i(key_char_q),
      .res_o     (lane_res[i])
    );
    assign hit[i]    = lane_res[i].hit;
    assign prog_d[i] = lane_res[i].prog;
  end

  // Register file writes; a defined index also wipes progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      chars_q   <= '0;
      lengths_q <= LENS_W'(16'h1111);
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx_e'(cfg_index_i))
          REG_COUNT: begin
            count_q <= cfg_data_i[CNT_W-1:0];
          end
          REG_CHARS_0: begin
            chars_q[0] <= cfg_data_i;
          end
          REG_CHARS_1: begin
            chars_q[1] <= cfg_data_i;
          end
          REG_CHARS_2: begin
            chars_q[2] <= cfg_data_i;
          end
          REG_CHARS_3: begin
            chars_q[3] <= cfg_data_i;
          end
          REG_LENGTHS: begin
            lengths_q <= cfg_data_i[LENS_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Progress state; a clear lands on the same edge as the write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q <= '0;
    end else if (cfg_clear) begin
      prog_q <= '0;
    end else if (advance) begin
      prog_q <= prog_d;
    end
  end

  // Input register and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (out_ready) begin
        in_valid_q <= 1'b0;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      key_char_q <= key_char_i;
    end
    if (advance) begin
      mask_q <= hit;
    end
  end

  `KKD_ASSERT_NEXT(a_cfg_clears_prog,
                   cfg_valid_i && cfg_ready_o && (cfg_index_i <= CFG_IDX_W'(REG_LENGTHS)),
                   prog_q == '0, "progress not cleared after register write")

  `KKD_ASSERT_NEXT(a_beat_reaches_out, in_valid_q && out_ready, out_valid_q,
                   "character beat did not reach result register")

  for (genvar i = 0; i < NUM_KEYWORDS; i++) begin : g_chk
    `KKD_ASSERT_NOW(a_prog_below_len, 1'b1,
                    {1'b0, prog_q[i]} < eff_len(lengths_q[LEN_W*i +: LEN_W]),
                    "progress at or past keyword length")
  end

endmodule

`default_nettype wire
